// ===== design/ucs_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 clause segmenter.
// No dependencies; imported by the segmenter top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ucs_pkg;

    // Default depth of the held-whitespace store.
    localparam int HELD_SPACE_DEPTH_DEF = 32;

    // Reset value of the weak-mark threshold register.
    localparam logic [7:0] MIN_WEAK_RESET = 8'd8;

    // Register indexes on the configuration port.
    localparam logic REG_MIN_WEAK = 1'b0;

    // Lead byte classification masks and patterns.
    localparam logic [7:0] LEAD_MASK1 = 8'h80;
    localparam logic [7:0] LEAD_MASK2 = 8'hE0;
    localparam logic [7:0] LEAD_PAT2  = 8'hC0;
    localparam logic [7:0] LEAD_MASK3 = 8'hF0;
    localparam logic [7:0] LEAD_PAT3  = 8'hE0;
    localparam logic [7:0] LEAD_MASK4 = 8'hF8;
    localparam logic [7:0] LEAD_PAT4  = 8'hF0;

    // Whitespace bytes and their stored codes.
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;

    localparam logic [1:0] WS_SPACE = 2'd0;
    localparam logic [1:0] WS_TAB   = 2'd1;
    localparam logic [1:0] WS_CR    = 2'd2;
    localparam logic [1:0] WS_LF    = 2'd3;

    // Single-byte clause marks.
    localparam logic [23:0] MARK_PERIOD    = 24'h00002E;
    localparam logic [23:0] MARK_EXCLAIM   = 24'h000021;
    localparam logic [23:0] MARK_QUESTION  = 24'h00003F;
    localparam logic [23:0] MARK_NEWLINE   = 24'h00000A;
    localparam logic [23:0] MARK_COMMA     = 24'h00002C;
    localparam logic [23:0] MARK_SEMICOLON = 24'h00003B;

    // Three-byte clause marks (ideographic full stop, fullwidth forms).
    localparam logic [23:0] MARK_IDEO_STOP = 24'hE38082;
    localparam logic [23:0] MARK_FW_EXCL   = 24'hEFBC81;
    localparam logic [23:0] MARK_FW_QUEST  = 24'hEFBC9F;
    localparam logic [23:0] MARK_FW_COMMA  = 24'hEFBC8C;
    localparam logic [23:0] MARK_FW_SEMI   = 24'hEFBC9B;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_BYTE,
        S_END
    } ucs_state_t;

    // Character length from the lead byte; malformed leads count as one byte.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & LEAD_MASK1) == 8'h00) begin
            len = 3'd1;
        end else if ((b & LEAD_MASK2) == LEAD_PAT2) begin
            len = 3'd2;
        end else if ((b & LEAD_MASK3) == LEAD_PAT3) begin
            len = 3'd3;
        end else if ((b & LEAD_MASK4) == LEAD_PAT4) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // True for the four ASCII whitespace bytes.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_CR) || (b == BYTE_LF);
    endfunction

    // Stored code of a whitespace byte.
    function automatic logic [1:0] ws_code(input logic [7:0] b);
        logic [1:0] code;
        case (b)
            BYTE_TAB: code = WS_TAB;
            BYTE_CR:  code = WS_CR;
            BYTE_LF:  code = WS_LF;
            default:  code = WS_SPACE;
        endcase
        return code;
    endfunction

    // Whitespace byte for a stored code.
    function automatic logic [7:0] ws_byte(input logic [1:0] code);
        logic [7:0] b;
        case (code)
            WS_TAB:  b = BYTE_TAB;
            WS_CR:   b = BYTE_CR;
            WS_LF:   b = BYTE_LF;
            default: b = BYTE_SPACE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/ucs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the held-whitespace store.
`timescale 1ns / 1ps
`default_nettype none

module ucs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/utf8_clause_segmenter.sv =====
// Top level of the UTF-8 clause segmenter: decoder, clause control and output stage.
// Depends on ucs_pkg and ucs_ram.
//
// Usage:
//   The input stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one text byte per
//   transfer; s_tuser set marks end of text, which flushes the clause and clears
//   all state. The result stream (m_*) carries clause bytes with leading and
//   trailing ASCII whitespace trimmed; m_tlast marks a clause end (m_tdata is
//   then zero) and m_tuser reports whitespace lost to a full store in the clause.
//   The APB port sets min_weak_chars (byte address 0). The user must make writes
//   only while idle; the block itself does not enforce this.
// Sequencing:
//   A byte is taken in S_IDLE. Before a non-whitespace byte, each held whitespace
//   byte is read from the held-whitespace RAM in S_READ and loaded into the output
//   register in S_DRAIN; S_BYTE then loads the byte and S_END any clause end.
//   Whitespace bytes return to S_IDLE, or go to S_END when they end a clause.
//   One item is worked on at a time; s_tready is high whenever the sequencer idles,
//   also while a finished result waits in the output register.
// Reset and stalls:
//   aresetn (synchronous, active low) clears all control state and restores the
//   threshold to 8. While m_tready is low a valid output register holds its
//   transfer, and the sequencer waits before loading another result into it.
`timescale 1ns / 1ps
`default_nettype none

module utf8_clause_segmenter #(
    parameter int HELD_SPACE_DEPTH = ucs_pkg::HELD_SPACE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] end_of_text
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,   // clause_end
    output logic             m_tuser,   // [0] whitespace_lost
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import ucs_pkg::*;

    localparam int AW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
    localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HELD_SPACE_DEPTH);

    // Configuration register.
    logic [7:0] min_weak_reg;

    // Clause and character state.
    ucs_state_t    state_reg, state_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic          started_reg, started_next;
    logic [7:0]    chars_reg, chars_next;
    logic [1:0]    left_reg, left_next;
    logic [23:0]   cbytes_reg, cbytes_next;
    logic [2:0]    clen_reg, clen_next;
    logic          ovf_reg, ovf_next;

    // Pending work for the accepted item.
    logic [7:0]    pend_byte_reg, pend_byte_next;
    logic          pend_end_reg, pend_end_next;
    logic          pend_ovf_reg, pend_ovf_next;
    logic [CW-1:0] drain_total_reg, drain_total_next;
    logic [CW-1:0] drain_idx_reg, drain_idx_next;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       m_user_reg, m_user_next;

    // Decode of the incoming byte against the current character state.
    logic       in_acc;
    logic       in_ws;
    logic [2:0] clen_n;
    logic [1:0] left_n;
    logic [23:0] cbytes_n;
    logic [7:0] chars_n;
    logic       complete;
    logic       strong_hit;
    logic       weak_hit;
    logic       out_free;

    // RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [1:0]    ram_wdata;
    logic          ram_re;
    logic [1:0]    ram_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_ws    = is_ws(s_tdata);
    assign out_free = !m_valid_reg || m_tready;

    // Character decoding: a new lead byte starts a character, others extend it.
    always_comb begin
        if (left_reg == 2'd0) begin
            clen_n   = lead_length(s_tdata);
            left_n   = 2'(clen_n - 3'd1);
            cbytes_n = {16'h0000, s_tdata};
            chars_n  = (chars_reg == 8'hFF) ? chars_reg : chars_reg + 8'd1;
        end else begin
            clen_n   = clen_reg;
            left_n   = left_reg - 2'd1;
            cbytes_n = {cbytes_reg[15:0], s_tdata};
            chars_n  = chars_reg;
        end
    end

    // Mark detection on a completed character; four-byte characters never match.
    assign complete = (left_n == 2'd0);
    always_comb begin
        strong_hit = 1'b0;
        weak_hit   = 1'b0;
        if (clen_n == 3'd1) begin
            strong_hit = (cbytes_n == MARK_PERIOD) || (cbytes_n == MARK_EXCLAIM) ||
                         (cbytes_n == MARK_QUESTION) || (cbytes_n == MARK_NEWLINE);
            weak_hit   = (cbytes_n == MARK_COMMA) || (cbytes_n == MARK_SEMICOLON);
        end else if (clen_n == 3'd3) begin
            strong_hit = (cbytes_n == MARK_IDEO_STOP) || (cbytes_n == MARK_FW_EXCL) ||
                         (cbytes_n == MARK_FW_QUEST);
            weak_hit   = (cbytes_n == MARK_FW_COMMA) || (cbytes_n == MARK_FW_SEMI);
        end
    end

    // Whitespace inside a started clause is pushed while the store has room.
    assign ram_we    = in_acc && !s_tuser && in_ws && started_reg &&
                       (held_count_reg < DEPTH_C);
    assign ram_waddr = held_count_reg[AW-1:0];
    assign ram_wdata = ws_code(s_tdata);
    assign ram_re    = (state_reg == S_READ);

    ucs_ram #(
        .WIDTH (2),
        .DEPTH (HELD_SPACE_DEPTH)
    ) u_held_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (drain_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer: takes one item, then releases held whitespace, the byte and the end mark.
    always_comb begin
        logic          bnd;
        logic          st_n;
        logic          ov_n;
        logic [CW-1:0] cnt_n;

        bnd   = 1'b0;
        st_n  = started_reg;
        ov_n  = ovf_reg;
        cnt_n = held_count_reg;

        state_next       = state_reg;
        held_count_next  = held_count_reg;
        started_next     = started_reg;
        chars_next       = chars_reg;
        left_next        = left_reg;
        cbytes_next      = cbytes_reg;
        clen_next        = clen_reg;
        ovf_next         = ovf_reg;
        pend_byte_next   = pend_byte_reg;
        pend_end_next    = pend_end_reg;
        pend_ovf_next    = pend_ovf_reg;
        drain_total_next = drain_total_reg;
        drain_idx_next   = drain_idx_reg;
        m_valid_next     = m_tready ? 1'b0 : m_valid_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        m_user_next      = m_user_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && s_tuser) begin
                    // End of text: flush a non-empty clause and clear everything.
                    pend_ovf_next   = ovf_reg;
                    state_next      = started_reg ? S_END : S_IDLE;
                    held_count_next = '0;
                    started_next    = 1'b0;
                    chars_next      = 8'd0;
                    ovf_next        = 1'b0;
                    left_next       = 2'd0;
                    cbytes_next     = 24'd0;
                    clen_next       = 3'd0;
                end else if (in_acc) begin
                    left_next   = left_n;
                    clen_next   = clen_n;
                    cbytes_next = cbytes_n;
                    if (in_ws) begin
                        if (started_reg) begin
                            if (held_count_reg < DEPTH_C) begin
                                cnt_n = held_count_reg + CW'(1);
                            end else begin
                                ov_n = 1'b1;
                            end
                        end
                    end else begin
                        if (started_reg) begin
                            cnt_n = '0;
                        end
                        st_n = 1'b1;
                    end
                    bnd = complete &&
                          (strong_hit || (weak_hit && (chars_n >= min_weak_reg)));

                    pend_byte_next   = s_tdata;
                    pend_end_next    = bnd && st_n;
                    pend_ovf_next    = ov_n;
                    drain_total_next = held_count_reg;
                    drain_idx_next   = '0;

                    if (!in_ws) begin
                        state_next = (started_reg && (held_count_reg != '0)) ? S_READ : S_BYTE;
                    end else begin
                        state_next = (bnd && st_n) ? S_END : S_IDLE;
                    end

                    // A boundary closes the clause state once its results are queued.
                    if (bnd) begin
                        held_count_next = '0;
                        started_next    = 1'b0;
                        chars_next      = 8'd0;
                        ovf_next        = 1'b0;
                    end else begin
                        held_count_next = cnt_n;
                        started_next    = st_n;
                        chars_next      = chars_n;
                        ovf_next        = ov_n;
                    end
                end
            end
            S_READ: begin
                state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = ws_byte(ram_rdata);
                    m_last_next    = 1'b0;
                    m_user_next    = pend_ovf_reg;
                    drain_idx_next = drain_idx_reg + CW'(1);
                    state_next     = ((drain_idx_reg + CW'(1)) == drain_total_reg) ?
                                     S_BYTE : S_READ;
                end
            end
            S_BYTE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_byte_reg;
                    m_last_next  = 1'b0;
                    m_user_next  = pend_ovf_reg;
                    state_next   = pend_end_reg ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = 8'h00;
                    m_last_next  = 1'b1;
                    m_user_next  = pend_ovf_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            held_count_reg <= '0;
            started_reg    <= 1'b0;
            chars_reg      <= 8'd0;
            left_reg       <= 2'd0;
            cbytes_reg     <= 24'd0;
            clen_reg       <= 3'd0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            started_reg    <= started_next;
            chars_reg      <= chars_next;
            left_reg       <= left_next;
            cbytes_reg     <= cbytes_next;
            clen_reg       <= clen_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_byte_reg   <= pend_byte_next;
        pend_end_reg    <= pend_end_next;
        pend_ovf_reg    <= pend_ovf_next;
        drain_total_reg <= drain_total_next;
        drain_idx_reg   <= drain_idx_next;
        m_data_reg      <= m_data_next;
        m_last_reg      <= m_last_next;
        m_user_reg      <= m_user_next;
    end

    // Configuration register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_weak_reg <= MIN_WEAK_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_WEAK)) begin
            min_weak_reg <= pwdata[7:0];
        end
    end

    // Configuration read and handshake.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_WEAK) ? {24'h000000, min_weak_reg} : 32'h0000_0000;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== design/ucs_checker.sv =====
// Port-level checker for the UTF-8 clause segmenter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module ucs_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       pready
);

    // No result is presented in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A clause end carries a zero byte.
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == 8'h00))
        else $error("clause end with nonzero byte");

    // Two clause ends never follow each other in back-to-back transfers.
    a_no_double_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tready && m_tlast))
        else $error("empty clause emitted");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // The configuration port never waits.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind utf8_clause_segmenter ucs_checker u_ucs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the UTF-8 clause segmenter: a byte stream goes in over the
// input stream, and every clause byte and clause end that comes out is checked in order.
// Depends on ucs_pkg and utf8_clause_segmenter.
`timescale 1ns / 1ps

module tb;
    import ucs_pkg::*;

    localparam int HELD_DEPTH = HELD_SPACE_DEPTH_DEF;
    localparam logic [2:0] MIN_WEAK_ADDR = {REG_MIN_WEAK, 2'b00};
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTED_ERRORS = 30;

    // One clause byte or clause end as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       clause_end;
        logic       ws_lost;
    } seg_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;
    logic        m_tuser;   // [0] whitespace_lost
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    utf8_clause_segmenter #(
        .HELD_SPACE_DEPTH(HELD_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted segmenter state.
    logic [7:0]  weak_threshold;
    logic [7:0]  held_bytes [HELD_DEPTH];
    int          held_total;
    logic        in_clause;
    logic [7:0]  clause_chars;
    logic [1:0]  cont_bytes_left;
    logic [23:0] char_value;
    logic [2:0]  char_size;
    logic        spaces_lost;

    seg_result_t expected_out[$];

    // Run control and statistics.
    int  error_count = 0;
    int  transfers_in = 0;
    int  transfers_out = 0;
    int  clause_ends_seen = 0;
    int  lost_flags_seen = 0;
    int  thresholds_used = 0;
    int  long_stalls_done = 0;
    int  hold_off_cycles = 0;
    bit  source_idles = 1'b0;
    bit  sink_idles = 1'b0;

    // Clock with a 2 ns period.
    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED_ERRORS) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    // Clears the per-clause part of the predicted state.
    function automatic void close_clause();
        held_total = 0;
        in_clause = 1'b0;
        clause_chars = 8'd0;
        spaces_lost = 1'b0;
    endfunction

    function automatic void expect_result(input logic [7:0] b, input logic last);
        seg_result_t r;
        r.data = b;
        r.clause_end = last;
        r.ws_lost = spaces_lost;
        expected_out = {expected_out, r};
    endfunction

    // Length of a character from its lead byte; malformed leads are one byte long.
    function automatic logic [2:0] char_length(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b0???????: len = 3'd1;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            default:     len = 3'd1;
        endcase
        return len;
    endfunction

    // Works out the results of one accepted byte and updates the predicted state.
    function automatic void segment_byte(input logic [7:0] b, input logic eot);
        logic is_space;
        logic strong_mark;
        logic weak_mark;

        strong_mark = 1'b0;
        weak_mark = 1'b0;

        // End of text closes a non-empty clause and clears everything.
        if (eot) begin
            if (in_clause) begin
                expect_result(8'h00, 1'b1);
            end
            close_clause();
            cont_bytes_left = 2'd0;
            char_value = 24'd0;
            char_size = 3'd0;
            return;
        end

        // Character framing.
        if (cont_bytes_left == 2'd0) begin
            char_size = char_length(b);
            cont_bytes_left = 2'(char_size - 3'd1);
            char_value = {16'd0, b};
            if (clause_chars != 8'hFF) begin
                clause_chars++;
            end
        end else begin
            cont_bytes_left--;
            char_value = {char_value[15:0], b};
        end

        // Whitespace is held inside a clause; anything else releases it and passes.
        is_space = (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_CR) || (b == BYTE_LF);
        if (is_space) begin
            if (in_clause) begin
                if (held_total < HELD_DEPTH) begin
                    held_bytes[held_total] = b;
                    held_total++;
                end else begin
                    spaces_lost = 1'b1;
                end
            end
        end else begin
            if (in_clause) begin
                for (int i = 0; i < held_total; i++) begin
                    expect_result(held_bytes[i], 1'b0);
                end
                held_total = 0;
            end else begin
                in_clause = 1'b1;
            end
            expect_result(b, 1'b0);
        end

        // Clause boundary on a completed character.
        if (cont_bytes_left == 2'd0) begin
            if (char_size == 3'd1) begin
                strong_mark = (char_value == MARK_PERIOD) || (char_value == MARK_EXCLAIM) ||
                              (char_value == MARK_QUESTION) || (char_value == MARK_NEWLINE);
                weak_mark = (char_value == MARK_COMMA) || (char_value == MARK_SEMICOLON);
            end else if (char_size == 3'd3) begin
                strong_mark = (char_value == MARK_IDEO_STOP) || (char_value == MARK_FW_EXCL) ||
                              (char_value == MARK_FW_QUEST);
                weak_mark = (char_value == MARK_FW_COMMA) || (char_value == MARK_FW_SEMI);
            end
            if (strong_mark || (weak_mark && clause_chars >= weak_threshold)) begin
                if (in_clause) begin
                    expect_result(8'h00, 1'b1);
                end
                close_clause();
            end
        end
    endfunction

    // Offers one byte, with an occasional idle burst first, and predicts on acceptance.
    task automatic send_item(input logic [7:0] b, input logic eot);
        if (source_idles && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        segment_byte(b, eot);
        transfers_in++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_item(text[i], 1'b0);
        end
    endtask

    task automatic send_repeat(input logic [7:0] b, input int count);
        repeat (count) send_item(b, 1'b0);
    endtask

    // Stops offering and waits until every predicted result has been transferred.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write followed by a read back.
    task automatic set_min_weak(input logic [7:0] value);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MIN_WEAK_ADDR;
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        weak_threshold = value;
        thresholds_used++;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {24'd0, value}) begin
            report_mismatch($sformatf("min_weak_chars read back 0x%08h, wrote 0x%02h",
                                      got, value));
        end
    endtask

    // Checks the register value left by reset.
    task automatic test_reset_value();
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MIN_WEAK_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {24'd0, MIN_WEAK_RESET}) begin
            report_mismatch($sformatf("min_weak_chars after reset is 0x%08h", got));
        end
        @(posedge aclk);
    endtask

    // Short directed text: trimming, multibyte marks, malformed bytes and end of text.
    task automatic test_directed();
        // Leading whitespace, a weak mark below the threshold, held whitespace.
        send_text("  Hi,\t x");
        // Ideographic full stop ends the clause.
        send_item(8'hE3, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h82, 1'b0);
        // Four-byte character, then malformed lead bytes.
        send_item(8'hF0, 1'b0);
        send_item(8'h9F, 1'b0);
        send_item(8'h98, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        // A space inside a broken three-byte character is still whitespace.
        send_item(8'hE3, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(8'h00, 1'b0);
        // End of text with a clause pending, then an empty flush.
        send_item(8'hA5, 1'b1);
        send_item(8'h00, 1'b1);
        // Fullwidth comma below the threshold, then a newline ends the clause.
        send_item(8'hEF, 1'b0);
        send_item(8'hBC, 1'b0);
        send_item(8'h8C, 1'b0);
        send_item(BYTE_LF, 1'b0);
        // A newline alone gives no clause end, as the clause is empty.
        send_item(BYTE_LF, 1'b0);
        wait_drained();
    endtask

    // Weak marks at the threshold extremes and at two middle values.
    task automatic test_weak_threshold();
        set_min_weak(8'd0);
        send_text(",  ;");
        send_item(8'hEF, 1'b0);
        send_item(8'hBC, 1'b0);
        send_item(8'h9B, 1'b0);
        wait_drained();

        set_min_weak(8'd1);
        send_text(" a;b , ");
        send_item(8'h00, 1'b1);
        wait_drained();

        set_min_weak(8'd255);
        send_text("ab,cd;e.");
        wait_drained();

        set_min_weak(8'd3);
        send_text("ab,a,b;.");
        wait_drained();
    endtask

    // Fills the held-whitespace store exactly, and past its end.
    task automatic test_store_overflow();
        // Overflow, then release of a full store.
        send_text("x");
        send_repeat(BYTE_SPACE, HELD_DEPTH + 8);
        send_text("y.q!");
        // A full store released before a stop gives the most results for one byte.
        send_text("p");
        for (int i = 0; i < HELD_DEPTH; i++) begin
            case (i % 4)
                0: send_item(BYTE_SPACE, 1'b0);
                1: send_item(BYTE_TAB, 1'b0);
                2: send_item(BYTE_CR, 1'b0);
                default: send_item(BYTE_LF, 1'b0);
            endcase
        end
        send_text(".");
        // Overflow flagged on the flush of end of text.
        send_text("r");
        send_repeat(BYTE_TAB, HELD_DEPTH + 1);
        send_item(8'h00, 1'b1);
        wait_drained();
    endtask

    // The result side holds off for a long time while the input keeps offering bytes.
    task automatic test_long_stall();
        source_idles = 1'b0;
        hold_off_cycles = 300;
        send_text("Stall test,   many bytes\tqueued here? ok.");
        wait_drained();
        source_idles = 1'b1;
    endtask

    // Random text: mostly well-formed words, marks and whitespace, some noise.
    task automatic random_text(input int item_budget);
        int start;
        int pick;
        int len;
        start = transfers_in;
        while (transfers_in - start < item_budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 34) begin
                send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
            end else if (pick < 48) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0: send_item(BYTE_TAB, 1'b0);
                        1: send_item(BYTE_CR, 1'b0);
                        default: send_item(BYTE_SPACE, 1'b0);
                    endcase
                end
            end else if (pick < 60) begin
                send_item(8'($urandom_range(8'hE4, 8'hE9)), 1'b0);
                send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
                send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end else if (pick < 64) begin
                send_item(8'($urandom_range(8'hC2, 8'hDF)), 1'b0);
                send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end else if (pick < 66) begin
                send_item(8'($urandom_range(8'hF0, 8'hF4)), 1'b0);
                repeat (3) send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end else if (pick < 78) begin
                case ($urandom_range(0, 3))
                    0: send_text(",");
                    1: send_text(";");
                    2: begin
                        send_item(MARK_FW_COMMA[23:16], 1'b0);
                        send_item(MARK_FW_COMMA[15:8], 1'b0);
                        send_item(MARK_FW_COMMA[7:0], 1'b0);
                    end
                    default: begin
                        send_item(MARK_FW_SEMI[23:16], 1'b0);
                        send_item(MARK_FW_SEMI[15:8], 1'b0);
                        send_item(MARK_FW_SEMI[7:0], 1'b0);
                    end
                endcase
            end else if (pick < 88) begin
                case ($urandom_range(0, 6))
                    0: send_text(".");
                    1: send_text("!");
                    2: send_text("?");
                    3: send_item(BYTE_LF, 1'b0);
                    4: begin
                        send_item(MARK_IDEO_STOP[23:16], 1'b0);
                        send_item(MARK_IDEO_STOP[15:8], 1'b0);
                        send_item(MARK_IDEO_STOP[7:0], 1'b0);
                    end
                    5: begin
                        send_item(MARK_FW_EXCL[23:16], 1'b0);
                        send_item(MARK_FW_EXCL[15:8], 1'b0);
                        send_item(MARK_FW_EXCL[7:0], 1'b0);
                    end
                    default: begin
                        send_item(MARK_FW_QUEST[23:16], 1'b0);
                        send_item(MARK_FW_QUEST[15:8], 1'b0);
                        send_item(MARK_FW_QUEST[7:0], 1'b0);
                    end
                endcase
            end else if (pick < 93) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 96) begin
                // Truncated multibyte character followed by plain text.
                send_item(8'($urandom_range(8'hE0, 8'hF4)), 1'b0);
                send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
                send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        wait_drained();
    endtask

    // Random text under several thresholds; the last phase runs without idling.
    task automatic test_random_text();
        logic [7:0] settings [5];
        settings[0] = 8'd0;
        settings[1] = 8'd255;
        settings[2] = 8'd2;
        settings[3] = 8'($urandom_range(3, 20));
        settings[4] = MIN_WEAK_RESET;
        for (int p = 0; p < 5; p++) begin
            if (p == 4) begin
                source_idles = 1'b0;
                sink_idles = 1'b0;
            end
            set_min_weak(settings[p]);
            random_text(14);
        end
    endtask

    // Result side: random ready bursts, plus a long hold-off on request.
    initial begin : result_sink
        int n;
        forever begin
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                long_stalls_done++;
            end else if (sink_idles && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Checks each result transfer against the oldest prediction.
    always @(posedge aclk) begin : result_check
        seg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            transfers_out++;
            if (m_tlast) clause_ends_seen++;
            if (m_tuser) lost_flags_seen++;
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer data=0x%02h last=%0b user=%0b",
                                          m_tdata, m_tlast, m_tuser));
            end else begin
                want = expected_out.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              m_tdata, want.data));
                end
                if (m_tlast !== want.clause_end) begin
                    report_mismatch($sformatf("clause_end %0b, expected %0b",
                                              m_tlast, want.clause_end));
                end
                if (m_tuser !== want.ws_lost) begin
                    report_mismatch($sformatf("whitespace_lost %0b, expected %0b",
                                              m_tuser, want.ws_lost));
                end
            end
        end
    end

    // Main sequence.
    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tuser <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'd0;
        pwdata <= 32'd0;
        weak_threshold = MIN_WEAK_RESET;
        close_clause();
        cont_bytes_left = 2'd0;
        char_value = 24'd0;
        char_size = 3'd0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_value();
        test_directed();
        source_idles = 1'b1;
        sink_idles = 1'b1;
        test_weak_threshold();
        test_store_overflow();
        test_long_stall();
        test_random_text();
        wait_drained();

        $display("Sent %0d input transfers and checked %0d result transfers",
                 transfers_in, transfers_out);
        $display("(%0d clause ends, %0d flagged for lost whitespace), %0d thresholds, %0d long stall(s).",
                 clause_ends_seen, lost_flags_seen, thresholds_used, long_stalls_done);
        if (error_count == 0 && expected_out.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
